>>> rtl/core/cpu_operand_address_modes_unit_assert.svh
// assertion macros for the operand address mode unit
`ifndef CPU_OPERAND_ADDRESS_MODES_UNIT_ASSERT_SVH
`define CPU_OPERAND_ADDRESS_MODES_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define CPUOAM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("cpu_oam: check failed");

// next-cycle implication, disabled while in reset
`define CPUOAM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("cpu_oam: check failed");

`endif

>>> rtl/core/cpu_oam_pkg.sv
`timescale 1ns / 1ps

package cpu_oam_pkg;

  typedef enum logic [3:0] {
    AM_ACCUM    = 4'd0,
    AM_ABSOL    = 4'd1,
    AM_ABSOL_X  = 4'd2,
    AM_ABSOL_Y  = 4'd3,
    AM_IMMED    = 4'd4,
    AM_IMPLIED  = 4'd5,
    AM_INDIR    = 4'd6,
    AM_INDIR_X  = 4'd7,
    AM_INDIR_Y  = 4'd8,
    AM_RELATIVE = 4'd9,
    AM_ZPAGE    = 4'd10,
    AM_ZPAGE_X  = 4'd11,
    AM_ZPAGE_Y  = 4'd12
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_LOW  = 2'd1,
    PH_HIGH = 2'd2
  } phase_e;

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  localparam logic RES_READ = 1'b0;
  localparam logic RES_DONE = 1'b1;

  localparam logic [1:0] OPND_NONE = 2'd0;
  localparam logic [1:0] OPND_BYTE = 2'd1;
  localparam logic [1:0] OPND_ADDR = 2'd2;

  function automatic logic [2:0] mode_cycles(input logic [3:0] m);
    logic [2:0] c;
    case (m) inside
      AM_ABSOL, AM_ABSOL_X, AM_ABSOL_Y: c = 3'd3;
      AM_IMMED, AM_RELATIVE:            c = 3'd1;
      AM_INDIR:                         c = 3'd7;
      AM_INDIR_X, AM_INDIR_Y:           c = 3'd5;
      AM_ZPAGE, AM_ZPAGE_X, AM_ZPAGE_Y: c = 3'd2;
      default:                          c = 3'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] mode_len(input logic [3:0] m);
    logic [1:0] n;
    case (m) inside
      AM_ABSOL, AM_ABSOL_X, AM_ABSOL_Y, AM_INDIR:                   n = 2'd2;
      AM_IMMED, AM_INDIR_X, AM_INDIR_Y, AM_RELATIVE, AM_ZPAGE,
      AM_ZPAGE_X, AM_ZPAGE_Y:                                       n = 2'd1;
      default:                                                      n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

>>> rtl/core/cpu_operand_address_modes_unit.sv
`timescale 1ns / 1ps

// channel  | direction | handshake                | payload
// ---------+-----------+--------------------------+------------------------------------------
// in       | in        | in_valid_i / in_stall_o  | kind, mode, op_lo/hi, pc, a, x, y, data
// out      | out       | out_valid_o / out_stall_i| result_kind, read_addr, arg_*, pc, cycles
//
// one request per cycle sustained while the result is not stalled
// each request is decoded from the input register into the result register, pointer
// state is updated there, so a read-data request may follow its read request directly
// reset clears the pointer fetch phase, no request is pending after reset
// a stalled result holds the result register, and the input register once it is full,
// so the input side stalls only when both are full and the result is stalled

module cpu_operand_address_modes_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [3:0]  mode_i,
  input  logic [7:0]  op_lo_i,
  input  logic [7:0]  op_hi_i,
  input  logic [15:0] pc_after_opcode_i,
  input  logic [7:0]  reg_a_i,
  input  logic [7:0]  reg_x_i,
  input  logic [7:0]  reg_y_i,
  input  logic [7:0]  read_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [15:0] read_addr_o,
  output logic [1:0]  arg_form_o,
  output logic [7:0]  arg_lo_o,
  output logic [7:0]  arg_hi_o,
  output logic [15:0] next_pc_o,
  output logic [2:0]  cycles_added_o,
  output logic        error_o
);
  import cpu_oam_pkg::*;

  logic        in_fire;
  logic        s1_adv;
  logic        s1_fire;
  logic        s1_valid_q, s1_valid_d;
  logic        s1_kind_q;
  logic [3:0]  s1_mode_q;
  logic [7:0]  s1_lo_q, s1_hi_q;
  logic [15:0] s1_pc_q;
  logic [7:0]  s1_a_q, s1_x_q, s1_y_q, s1_rd_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  pending_q, pending_d;
  logic [15:0] ptr_q, ptr_d;
  logic [7:0]  plow_q, plow_d;
  logic [7:0]  sy_q, sy_d;
  logic [15:0] snpc_q, snpc_d;

  logic        out_valid_q, out_valid_d;
  logic        rkind_q, rkind_d;
  logic [15:0] raddr_q, raddr_d;
  logic [1:0]  atype_q, atype_d;
  logic [7:0]  alo_q, alo_d;
  logic [7:0]  ahi_q, ahi_d;
  logic [15:0] npc_q, npc_d;
  logic [2:0]  cyc_q, cyc_d;
  logic        err_q, err_d;

  logic [15:0] npc;
  logic [15:0] abs_addr;
  logic [15:0] abx_addr;
  logic [15:0] aby_addr;
  logic [15:0] rel_addr;
  logic [15:0] ptr_inc;
  logic [15:0] fetched;

  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign s1_fire    = s1_valid_q && s1_adv;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_fire    = in_valid_i && !in_stall_o;
  assign s1_valid_d = in_fire || (s1_valid_q && !s1_adv);
  assign out_valid_d = s1_fire || (out_valid_q && out_stall_i);

  assign npc      = s1_pc_q + {14'b0, mode_len(s1_mode_q)};
  assign abs_addr = {s1_hi_q, s1_lo_q};
  assign abx_addr = abs_addr + {8'h00, s1_x_q};
  assign aby_addr = abs_addr + {8'h00, s1_y_q};
  assign rel_addr = npc + {{8{s1_lo_q[7]}}, s1_lo_q};
  assign ptr_inc  = (pending_q == AM_INDIR) ? ptr_q + 16'd1 : {8'h00, ptr_q[7:0] + 8'd1};
  assign fetched  = {s1_rd_q, plow_q} + ((pending_q == AM_INDIR_Y) ? {8'h00, sy_q} : 16'h0000);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      pending_q   <= AM_ACCUM;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_fire) begin
        phase_q   <= phase_d;
        pending_q <= pending_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q <= kind_i;
      s1_mode_q <= mode_i;
      s1_lo_q   <= op_lo_i;
      s1_hi_q   <= op_hi_i;
      s1_pc_q   <= pc_after_opcode_i;
      s1_a_q    <= reg_a_i;
      s1_x_q    <= reg_x_i;
      s1_y_q    <= reg_y_i;
      s1_rd_q   <= read_data_i;
    end
    if (s1_fire) begin
      ptr_q   <= ptr_d;
      plow_q  <= plow_d;
      sy_q    <= sy_d;
      snpc_q  <= snpc_d;
      rkind_q <= rkind_d;
      raddr_q <= raddr_d;
      atype_q <= atype_d;
      alo_q   <= alo_d;
      ahi_q   <= ahi_d;
      npc_q   <= npc_d;
      cyc_q   <= cyc_d;
      err_q   <= err_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    pending_d = pending_q;
    ptr_d     = ptr_q;
    plow_d    = plow_q;
    sy_d      = sy_q;
    snpc_d    = snpc_q;
    rkind_d   = RES_DONE;
    raddr_d   = '0;
    atype_d   = OPND_NONE;
    alo_d     = '0;
    ahi_d     = '0;
    npc_d     = '0;
    cyc_d     = '0;
    err_d     = 1'b0;
    if (s1_kind_q == KIND_DATA) begin
      unique case (phase_q)
        PH_LOW: begin
          plow_d  = s1_rd_q;
          ptr_d   = ptr_inc;
          phase_d = PH_HIGH;
          rkind_d = RES_READ;
          raddr_d = ptr_inc;
        end
        PH_HIGH: begin
          phase_d = PH_IDLE;
          atype_d = OPND_ADDR;
          alo_d   = fetched[7:0];
          ahi_d   = fetched[15:8];
          npc_d   = snpc_q;
          cyc_d   = mode_cycles(pending_q);
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end else begin
      phase_d = PH_IDLE;
      npc_d   = npc;
      cyc_d   = mode_cycles(s1_mode_q);
      unique case (s1_mode_q) inside
        AM_ACCUM: begin
          atype_d = OPND_BYTE;
          alo_d   = s1_a_q;
        end
        AM_IMMED: begin
          atype_d = OPND_BYTE;
          alo_d   = s1_lo_q;
        end
        AM_IMPLIED: begin
          atype_d = OPND_NONE;
        end
        AM_ABSOL: begin
          atype_d = OPND_ADDR;
          alo_d   = abs_addr[7:0];
          ahi_d   = abs_addr[15:8];
        end
        AM_ABSOL_X: begin
          atype_d = OPND_ADDR;
          alo_d   = abx_addr[7:0];
          ahi_d   = abx_addr[15:8];
        end
        AM_ABSOL_Y: begin
          atype_d = OPND_ADDR;
          alo_d   = aby_addr[7:0];
          ahi_d   = aby_addr[15:8];
        end
        AM_RELATIVE: begin
          atype_d = OPND_ADDR;
          alo_d   = rel_addr[7:0];
          ahi_d   = rel_addr[15:8];
        end
        AM_ZPAGE: begin
          atype_d = OPND_ADDR;
          alo_d   = s1_lo_q;
        end
        AM_ZPAGE_X: begin
          atype_d = OPND_ADDR;
          alo_d   = s1_lo_q + s1_x_q;
        end
        AM_ZPAGE_Y: begin
          atype_d = OPND_ADDR;
          alo_d   = s1_lo_q + s1_y_q;
        end
        AM_INDIR, AM_INDIR_X, AM_INDIR_Y: begin
          // pointer fetch, low byte first
          if (s1_mode_q == AM_INDIR) begin
            ptr_d = abs_addr;
          end else if (s1_mode_q == AM_INDIR_X) begin
            ptr_d = {8'h00, s1_lo_q + s1_x_q};
          end else begin
            ptr_d = {8'h00, s1_lo_q};
          end
          pending_d = s1_mode_q;
          sy_d      = s1_y_q;
          snpc_d    = npc;
          phase_d   = PH_LOW;
          rkind_d   = RES_READ;
          raddr_d   = ptr_d;
          npc_d     = '0;
          cyc_d     = '0;
        end
        default: begin
          err_d = 1'b1;
          npc_d = '0;
          cyc_d = '0;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = rkind_q;
  assign read_addr_o    = raddr_q;
  assign arg_form_o     = atype_q;
  assign arg_lo_o       = alo_q;
  assign arg_hi_o       = ahi_q;
  assign next_pc_o      = npc_q;
  assign cycles_added_o = cyc_q;
  assign error_o        = err_q;

endmodule

>>> rtl/core/cpu_oam_checker.sv
`timescale 1ns / 1ps
`include "cpu_operand_address_modes_unit_assert.svh"

module cpu_oam_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [15:0] read_addr_o,
  input logic [1:0]  arg_form_o,
  input logic [7:0]  arg_lo_o,
  input logic [7:0]  arg_hi_o,
  input logic [15:0] next_pc_o,
  input logic [2:0]  cycles_added_o,
  input logic        error_o
);
  import cpu_oam_pkg::*;

  logic out_held;
  logic read_req;
  logic errored;
  logic in_held;

  assign out_held = out_valid_o && out_stall_i;
  assign read_req = out_valid_o && (result_kind_o == RES_READ);
  assign errored  = out_valid_o && error_o;
  assign in_held  = in_valid_i && in_stall_o;

  // a stalled result keeps its read address, argument bytes, next pc and result kind
  `CPUOAM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(read_addr_o) && $stable(arg_lo_o) && $stable(arg_hi_o) && $stable(next_pc_o) && $stable(result_kind_o))

  // read requests carry only an address
  `CPUOAM_ASSERT_NOW(a_read_only_addr, clk_i, rst_ni, read_req, arg_form_o == OPND_NONE && next_pc_o == 16'h0000 && cycles_added_o == 3'd0 && !error_o)

  // errors are completed results with nothing else set
  `CPUOAM_ASSERT_NOW(a_error_clean, clk_i, rst_ni, errored, result_kind_o == RES_DONE && read_addr_o == 16'h0000 && arg_form_o == OPND_NONE && next_pc_o == 16'h0000 && cycles_added_o == 3'd0)

  // byte arguments leave the high byte clear
  `CPUOAM_ASSERT_NOW(a_byte_hi_zero, clk_i, rst_ni, out_valid_o && arg_form_o == OPND_BYTE, arg_hi_o == 8'h00 && read_addr_o == 16'h0000)

  // the input side only stalls behind a stalled result
  `CPUOAM_ASSERT_NOW(a_in_stall_cause, clk_i, rst_ni, in_held, out_valid_o && out_stall_i)

endmodule

bind cpu_operand_address_modes_unit cpu_oam_checker u_cpu_oam_checker (.*);
